>>> hdl/ucd_pkg.sv
// Shared types and constants of the UTF-8 control code detector.
// Used by ucd_ctrl, ucd_datapath and utf8_control_code_detector; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

   // Default width of the internal byte counters
   localparam int INDEX_BITS_DEFAULT = 16;

   // Widths fixed by the item formats
   localparam int BYTE_BITS  = 8;
   localparam int MASK_BITS  = 3;
   localparam int FIRST_BITS = 16;
   localparam int PEND_DEPTH = 7;
   localparam int COUNT_BITS = 3;

   // Byte classes
   localparam logic [7:0] LEAD_MIN   = 8'hC0;
   localparam logic [1:0] CONT_TAG   = 2'b10;
   localparam logic [7:0] C0_END     = 8'h20;
   localparam logic [7:0] DEL_CODE   = 8'h7F;
   localparam logic [7:0] C1_FIRST   = 8'h80;
   localparam logic [7:0] C1_LAST    = 8'h9F;

   // Bits of the forbidden class mask
   localparam int MASK_WS = 0;
   localparam int MASK_C0 = 1;
   localparam int MASK_C1 = 2;

   // Input item
   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 last_byte;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic                  found;
      logic [FIRST_BITS-1:0] first_index;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic push;   // store the accepted byte
      logic step;   // one decode step on the front of the buffer
      logic load;   // post the result and clear the string state
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic ends;      // the current step leaves the buffer empty or waiting
      logic last;      // the buffered bytes end the string
      logic out_busy;  // result register full and stalled
   } sts_type;

endpackage

`default_nettype wire

>>> hdl/ucd_ctrl.sv
// Controller of the UTF-8 control code detector: accept, decode steps, result post.
// Depends on ucd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucd_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output ucd_pkg::cmd_type     cmd,
   input  ucd_pkg::sts_type     sts
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (sts.ends) state_in = sts.last ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (!sts.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   assign req_stall = (state_ff != ST_IDLE);
   assign cmd.push  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.step  = (state_ff == ST_DRAIN);
   assign cmd.load  = (state_ff == ST_FLUSH) && !sts.out_busy;

   // An accepted byte is always followed by a decode step
   a_push_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> cmd.step)
      else $error("accepted item not followed by a decode step");

   // No item is taken while a finished string waits to be posted
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> !cmd.push)
      else $error("item accepted while result pending");

endmodule

`default_nettype wire

>>> hdl/ucd_datapath.sv
// Datapath of the UTF-8 control code detector: pending buffer, decoder, hit tracking,
// class mask and result register. Depends on ucd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ucd_datapath #(
   parameter int INDEX_BITS = ucd_pkg::INDEX_BITS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  ucd_pkg::req_item_type              req_item,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output ucd_pkg::rsp_item_type              rsp_item,
   input  wire                                csr_wr_en,
   input  wire [ucd_pkg::MASK_BITS-1:0]       csr_wr_data,
   input  ucd_pkg::cmd_type                   cmd,
   output ucd_pkg::sts_type                   sts
);

   localparam int BB   = ucd_pkg::BYTE_BITS;
   localparam int PD   = ucd_pkg::PEND_DEPTH;
   localparam int CB   = ucd_pkg::COUNT_BITS;
   localparam int FB   = ucd_pkg::FIRST_BITS;
   localparam int WIDE = (INDEX_BITS > FB) ? INDEX_BITS : FB;

   // Class check of one decoded code point below 0x100
   function automatic logic is_forbidden(input logic [BB-1:0] cp,
                                         input logic [ucd_pkg::MASK_BITS-1:0] mask);
      logic res;
      begin
         if (cp inside {8'd9, 8'd10, 8'd11, 8'd13})
            res = mask[ucd_pkg::MASK_WS];
         else if (cp < ucd_pkg::C0_END || cp == ucd_pkg::DEL_CODE)
            res = mask[ucd_pkg::MASK_C0];
         else if (cp inside {[ucd_pkg::C1_FIRST:ucd_pkg::C1_LAST]})
            res = mask[ucd_pkg::MASK_C1];
         else
            res = 1'b0;
         return res;
      end
   endfunction

   // Sequence length from the lead byte
   function automatic logic [CB-1:0] seq_length(input logic [BB-1:0] lead);
      logic [CB-1:0] len;
      begin
         if (lead >= 8'hFC)      len = 3'd6;
         else if (lead >= 8'hF8) len = 3'd5;
         else if (lead >= 8'hF0) len = 3'd4;
         else if (lead >= 8'hE0) len = 3'd3;
         else                    len = 3'd2;
         return len;
      end
   endfunction

   // Registers
   logic [ucd_pkg::MASK_BITS-1:0] mask_ff;
   logic [BB-1:0]                 pend_ff [PD];
   logic [BB-1:0]                 pend_in [PD];
   logic [CB-1:0]                 count_ff;
   logic                          last_ff;
   logic [INDEX_BITS-1:0]         byte_index_ff;
   logic [INDEX_BITS-1:0]         byte_index_in;
   logic                          hit_seen_ff;
   logic [INDEX_BITS-1:0]         hit_index_ff;
   logic                          rsp_valid_ff;
   ucd_pkg::rsp_item_type         rsp_item_ff;
   ucd_pkg::rsp_item_type         rsp_item_in;

   // Decode of the buffer front
   logic [BB-1:0]   lead;
   logic            is_single;
   logic [CB-1:0]   seq_len;
   logic [PD-1:0]   cont_ok;
   logic            broken;
   logic            complete;
   logic [31:0]     acc;
   logic [CB-1:0]   drop_k;
   logic            note_valid;
   logic            note_big;
   logic [BB-1:0]   note_low;
   logic            note_hit;
   logic [INDEX_BITS:0] bi_sum;
   logic [PD*BB-1:0]    flat;
   logic [PD*BB-1:0]    flat_sh;
   logic [WIDE-1:0]     hit_wide;

   assign lead      = pend_ff[0];
   assign is_single = (lead < ucd_pkg::LEAD_MIN);
   assign seq_len   = seq_length(lead);

   // Continuation checks over the buffered bytes behind the lead
   always_comb begin
      broken = 1'b0;
      for (int j = 0; j < PD; j++) begin
         cont_ok[j] = (pend_ff[j][BB-1 -: 2] == ucd_pkg::CONT_TAG);
         if (j >= 1 && CB'(j) < count_ff && CB'(j) < seq_len && !cont_ok[j])
            broken = 1'b1;
      end
   end

   assign complete = !broken && (count_ff >= seq_len);

   // Assembled code point for each sequence length
   always_comb begin
      case (seq_len)
         3'd2:    acc = 32'({lead[4:0], pend_ff[1][5:0]});
         3'd3:    acc = 32'({lead[3:0], pend_ff[1][5:0], pend_ff[2][5:0]});
         3'd4:    acc = 32'({lead[2:0], pend_ff[1][5:0], pend_ff[2][5:0],
                             pend_ff[3][5:0]});
         3'd5:    acc = 32'({lead[1:0], pend_ff[1][5:0], pend_ff[2][5:0],
                             pend_ff[3][5:0], pend_ff[4][5:0]});
         3'd6:    acc = {lead[1:0], pend_ff[1][5:0], pend_ff[2][5:0],
                         pend_ff[3][5:0], pend_ff[4][5:0], pend_ff[5][5:0]};
         default: acc = '0;
      endcase
   end

   // Step outcome: bytes dropped and code point noted
   always_comb begin
      note_valid = 1'b0;
      note_big   = 1'b0;
      note_low   = lead;
      if (is_single) begin
         drop_k     = 3'd1;
         note_valid = 1'b1;
      end else if (broken) begin
         drop_k = 3'd1;                     // lead skipped
      end else if (complete) begin
         drop_k     = seq_len;
         note_valid = 1'b1;
         note_big   = (acc[31:BB] != '0);
         note_low   = acc[BB-1:0];
      end else if (last_ff) begin
         drop_k = 3'd1;                     // cut off by end of string
      end else begin
         drop_k = 3'd0;                     // wait for more bytes
      end
   end

   assign note_hit = note_valid && !note_big && !hit_seen_ff && is_forbidden(note_low, mask_ff);

   // Saturating index advance
   assign bi_sum = {1'b0, byte_index_ff} + (INDEX_BITS+1)'(drop_k);
   assign byte_index_in = bi_sum[INDEX_BITS] ? '1 : bi_sum[INDEX_BITS-1:0];

   // Buffer shift by the dropped byte count
   always_comb begin
      for (int i = 0; i < PD; i++) flat[i*BB +: BB] = pend_ff[i];
      flat_sh = flat >> {drop_k, 3'b000};
      for (int i = 0; i < PD; i++) begin
         pend_in[i] = pend_ff[i];
         if (cmd.step) pend_in[i] = flat_sh[i*BB +: BB];
      end
      if (cmd.push && count_ff < CB'(PD)) pend_in[count_ff] = req_item.data_byte;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PD; i++) pend_ff[i] <= pend_in[i];
   end

   // Result item, first index saturated to the output width
   assign hit_wide = WIDE'(hit_index_ff);
   always_comb begin
      rsp_item_in.found       = hit_seen_ff;
      rsp_item_in.first_index = '0;
      if (hit_seen_ff)
         rsp_item_in.first_index = (hit_wide > WIDE'({FB{1'b1}})) ? {FB{1'b1}}
                                                                 : hit_wide[FB-1:0];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '0;
         count_ff      <= '0;
         last_ff       <= 1'b0;
         byte_index_ff <= '0;
         hit_seen_ff   <= 1'b0;
         hit_index_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) mask_ff <= csr_wr_data;
         if (cmd.push) begin
            if (count_ff < CB'(PD)) count_ff <= count_ff + 3'd1;
            last_ff <= req_item.last_byte;
         end
         if (cmd.step) begin
            count_ff      <= count_ff - drop_k;
            byte_index_ff <= byte_index_in;
            if (note_hit) begin
               hit_seen_ff  <= 1'b1;
               hit_index_ff <= byte_index_ff;
            end
         end
         if (cmd.load) begin
            rsp_valid_ff  <= 1'b1;
            count_ff      <= '0;
            last_ff       <= 1'b0;
            byte_index_ff <= '0;
            hit_seen_ff   <= 1'b0;
            hit_index_ff  <= '0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.load) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_item_ff;
   assign sts.ends     = (drop_k == 3'd0) || (count_ff == drop_k);
   assign sts.last     = last_ff;
   assign sts.out_busy = rsp_valid_ff && rsp_stall;

   // A drained buffer never holds a full depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != CB'(PD))
      else $error("pending buffer overfilled");

   // The recorded hit never lies beyond the current position
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      hit_seen_ff |-> (hit_index_ff <= byte_index_ff))
      else $error("hit index ahead of byte index");

   // Posting a result clears the string state
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (!hit_seen_ff && byte_index_ff == '0 && count_ff == '0))
      else $error("string state not cleared after result");

   // A waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten");

endmodule

`default_nettype wire

>>> hdl/utf8_control_code_detector.sv
// UTF-8 control code detector: scans the bytes of a string for forbidden controls.
// Top level; depends on ucd_pkg, ucd_ctrl and ucd_datapath.
//
// Input channel (req_): one byte per item, last_byte set on the final byte of a string.
// Result channel (rsp_): one item per string, found and the byte index where the
// first forbidden code point starts (0 when none), saturating at 65535.
// Configuration (csr_): csr_wr_en writes the 3-bit class mask (bit0 whitespace,
// bit1 C0 and DEL, bit2 C1); write it only while the block is idle.
//
// Sequencing: an item is accepted, then decoded by one decode step on the
// pending buffer; the final byte of a string then moves on to posting its result.
// After a broken or truncated sequence each replayed byte costs one more
// decode step; the decode step unit handles one sequence or one byte per cycle.
// The result is registered on posting, once the result register is free.
// Reset clears the mask, the string state and the result valid flag.
// While rsp_stall holds a result, further strings are still taken; the block stalls
// req_ during decode steps and while a finished string's result waits to be posted.
`timescale 1ns / 1ps
`default_nettype none

module utf8_control_code_detector #(
   parameter int INDEX_BITS = ucd_pkg::INDEX_BITS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  ucd_pkg::req_item_type          req_item,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output ucd_pkg::rsp_item_type          rsp_item,
   input  wire                            csr_wr_en,
   input  wire [ucd_pkg::MASK_BITS-1:0]   csr_wr_data
);

   ucd_pkg::cmd_type cmd;
   ucd_pkg::sts_type sts;

   // Sequencer
   ucd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Buffer, decoder and result register
   ucd_datapath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

>>> sim/ucd_string_checker.sv
// Predicting checker for the UTF-8 control code detector: watches the byte and result
// channels and the mask port, predicts each string's verdict and compares it.
// Depends on ucd_pkg for the item types, widths and mask bit positions.
`timescale 1ns / 1ps

module ucd_string_checker (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire                          req_stall,
   input  ucd_pkg::req_item_type        req_item,
   input  wire                          rsp_valid,
   input  wire                          rsp_stall,
   input  ucd_pkg::rsp_item_type        rsp_item,
   input  wire                          csr_wr_en,
   input  wire [ucd_pkg::MASK_BITS-1:0] csr_wr_data,
   output int                           outstanding,
   output int                           mismatches,
   output int                           strings_checked
);
   import ucd_pkg::*;

   localparam int unsigned INDEX_LIMIT = (1 << INDEX_BITS_DEFAULT) - 1;
   localparam int unsigned FIRST_LIMIT = (1 << FIRST_BITS) - 1;

   // whitespace controls, governed by the whitespace bit alone
   localparam logic [7:0] TAB_CODE = 8'h09;
   localparam logic [7:0] LF_CODE  = 8'h0A;
   localparam logic [7:0] VT_CODE  = 8'h0B;
   localparam logic [7:0] CR_CODE  = 8'h0D;

   // predicted decoder state for the current string
   logic [7:0]           held [PEND_DEPTH];
   int unsigned          held_count;
   int unsigned          scan_index;
   int unsigned          hit_at;
   bit                   hit_flag;
   logic [MASK_BITS-1:0] class_mask;

   // verdicts of completed strings, oldest first
   rsp_item_type string_verdicts [$];

   function automatic bit banned(input logic [7:0] point);
      if (point == TAB_CODE || point == LF_CODE || point == VT_CODE || point == CR_CODE)
         return class_mask[MASK_WS];
      if (point < C0_END || point == DEL_CODE)
         return class_mask[MASK_C0];
      if (point >= C1_FIRST && point <= C1_LAST)
         return class_mask[MASK_C1];
      return 1'b0;
   endfunction

   // sequence length from the run of leading ones, clamped to 2..6
   function automatic int unsigned run_length(input logic [7:0] lead);
      int unsigned ones = 0;
      while (ones < 8 && lead[7 - ones])
         ones++;
      return (ones > 6) ? 6 : ((ones < 2) ? 2 : ones);
   endfunction

   task automatic clear_string();
      held_count = 0;
      scan_index = 0;
      hit_at     = 0;
      hit_flag   = 1'b0;
   endtask

   // keep only the first forbidden code point of a string
   task automatic note_point(input bit big, input logic [7:0] low);
      if (!hit_flag && !big && banned(low)) begin
         hit_flag = 1'b1;
         hit_at   = scan_index;
      end
   endtask

   // drop bytes off the front of the buffer; index saturates
   task automatic retire(input int unsigned count);
      int unsigned k;
      k = (count > held_count) ? held_count : count;
      for (int unsigned i = 0; i + k < held_count; i++)
         held[i] = held[i + k];
      held_count -= k;
      scan_index = (scan_index + k > INDEX_LIMIT) ? INDEX_LIMIT : scan_index + k;
   endtask

   // decode as much of the buffer as possible
   task automatic settle_buffer(input bit at_end);
      logic [7:0]  lead;
      logic [31:0] acc;
      int unsigned len;
      int unsigned j;
      bit          broken;
      bit          waiting;
      waiting = 1'b0;
      while (held_count > 0 && !waiting) begin
         lead = held[0];
         if (lead < LEAD_MIN) begin
            note_point(1'b0, lead);
            retire(1);
         end else begin
            len    = run_length(lead);
            acc    = 32'(lead & ((len == 6) ? 8'h03 : 8'hFF >> (len + 1)));
            broken = 1'b0;
            j      = 1;
            while (j < held_count && j < len && !broken) begin
               if (held[j][7:6] != CONT_TAG)
                  broken = 1'b1;
               else begin
                  acc = {acc[25:0], held[j][5:0]};
                  j++;
               end
            end
            if (broken)
               retire(1);          // broken sequence: skip the lead only
            else if (j == len) begin
               note_point(acc >= 32'd256, acc[7:0]);
               retire(len);
            end else if (at_end)
               retire(1);          // cut off by the end of the string
            else
               waiting = 1'b1;
         end
      end
   endtask

   // one accepted byte; a verdict is queued at the end of a string
   task automatic scan_byte(input req_item_type item);
      rsp_item_type verdict;
      if (held_count < PEND_DEPTH) begin
         held[held_count] = item.data_byte;
         held_count++;
      end
      settle_buffer(item.last_byte);
      if (item.last_byte) begin
         verdict.found       = hit_flag;
         verdict.first_index = hit_flag ?
            FIRST_BITS'((hit_at > FIRST_LIMIT) ? FIRST_LIMIT : hit_at) : '0;
         string_verdicts.push_back(verdict);
         clear_string();
      end
   endtask

   // results are compared before the byte of the same edge is predicted
   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         clear_string();
         class_mask = '0;
         string_verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (string_verdicts.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual found %0b index %0d",
                        $time, rsp_item.found, rsp_item.first_index);
            end else begin
               want = string_verdicts.pop_front();
               strings_checked++;
               if (rsp_item.found !== want.found) begin
                  mismatches++;
                  $display("%0t: found mismatch, expected %0b actual %0b",
                           $time, want.found, rsp_item.found);
               end
               if (rsp_item.first_index !== want.first_index) begin
                  mismatches++;
                  $display("%0t: first_index mismatch, expected %0d actual %0d",
                           $time, want.first_index, rsp_item.first_index);
               end
            end
         end
         if (csr_wr_en)
            class_mask = csr_wr_data;
         if (req_valid && !req_stall)
            scan_byte(req_item);
      end
      outstanding = string_verdicts.size();
   end

endmodule

>>> sim/testbench.sv
// Top of the UTF-8 control code detector testbench: clock, reset, byte stimulus,
// result-side stalls and the verdict. Depends on ucd_pkg, the detector and ucd_string_checker.
`timescale 1ns / 1ps

module testbench;
   import ucd_pkg::*;

   localparam int LONG_HOLD     = 240;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_BYTES   = 100;
   localparam int PHASES        = 10;
   localparam int HOLD_PHASE    = 3;
   localparam int HOLD_STRINGS  = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_item_type         req_item;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_item_type         rsp_item;
   logic                 csr_wr_en;
   logic [MASK_BITS-1:0] csr_wr_data;

   int         outstanding;
   int         mismatches;
   int         strings_checked;
   int         bytes_sent   = 0;
   int         hold_token   = 0;
   int         holds_served = 0;
   bit         idle_enable  = 1'b0;
   logic [7:0] draft [$];

   utf8_control_code_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ucd_string_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .outstanding     (outstanding),
      .mismatches      (mismatches),
      .strings_checked (strings_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // result side: long hold-off on request, otherwise random stall bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_token != holds_served) begin
            holds_served = hold_token;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            if (idle_enable)
               repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= '{data_byte: value, last_byte: last};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // send the drafted string, last flag on its final byte
   task automatic send_draft();
      for (int i = 0; i < draft.size(); i++) begin
         if (idle_enable && $urandom_range(0, 4) == 0)
            pause_sender($urandom_range(1, 14));
         send_byte(draft[i], i == draft.size() - 1);
      end
      draft.delete();
   endtask

   // up to eight bytes, first byte in the top used lane
   task automatic send_packed(input logic [63:0] packed_text, input int count);
      for (int i = count - 1; i >= 0; i--)
         draft.push_back(packed_text[8*i +: 8]);
      send_draft();
   endtask

   // idle the sender and let every pending verdict arrive
   task automatic wait_results();
      pause_sender(1);
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_mask(input logic [MASK_BITS-1:0] value);
      wait_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_idling(input bit on);
      @(posedge clock);
      idle_enable = on;
   endtask

   // encoding of a code point in len bytes, with only conts continuation bytes
   task automatic put_sequence(input logic [31:0] point, input int unsigned len,
                               input int unsigned conts);
      logic [7:0] prefix;
      logic [7:0] lead_mask;
      prefix    = ~(8'hFF >> len);
      lead_mask = (len == 6) ? 8'h03 : 8'hFF >> (len + 1);
      draft.push_back(prefix | (8'(point >> (6 * (len - 1))) & lead_mask));
      for (int unsigned j = 1; j <= conts; j++)
         draft.push_back({CONT_TAG, 6'(point >> (6 * (len - 1 - j)))});
   endtask

   // one random piece of text: mostly well formed, some broken or stray bytes
   task automatic put_token();
      int unsigned len;
      logic [31:0] point;
      len   = $urandom_range(2, 6);
      point = $urandom_range(0, 1) ? 32'($urandom_range(0, 255)) : 32'($urandom);
      case ($urandom_range(0, 9))
         0, 1, 2: draft.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                       : 8'($urandom_range(0, 127)));
         3, 4, 5, 6: put_sequence(point, len, len - 1);
         7: begin
            put_sequence(point, len, $urandom_range(0, len - 2));
            draft.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                 : 8'($urandom_range(192, 255)));
         end
         8: draft.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
                                                 : 8'($urandom_range(0, 255)));
         default: put_sequence(point, len, $urandom_range(0, len - 2));
      endcase
   endtask

   initial begin
      int phase_start;
      req_valid   = 1'b0;
      req_item    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      reset       = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed strings, every class forbidden
      set_mask('1);
      send_packed(64'h41, 1);
      send_packed(64'h00, 1);
      send_packed(64'h4109, 2);
      send_packed(64'hFF, 1);                 // lone lead cut off at the end
      send_packed(64'hC280, 2);
      send_packed(64'hC080, 2);               // overlong NUL
      send_packed(64'hC24185, 3);             // broken, stray C1 after it
      send_packed(64'hE282, 2);               // truncated, stray C1 replayed
      send_packed(64'hE282AC7F, 4);           // wide code point, then DEL
      send_packed(64'hFC8080808080, 6);       // six-byte overlong NUL

      // whitespace follows its own bit only
      set_mask(MASK_BITS'(1 << MASK_C0));
      send_packed(64'h0A01, 2);
      set_mask(MASK_BITS'(1 << MASK_WS));
      send_packed(64'h010B, 2);

      // random phases over all masks; the final one runs without idling
      for (int phase = 0; phase < PHASES; phase++) begin
         set_mask((phase < 8) ? MASK_BITS'(7 - phase) : MASK_BITS'($urandom_range(0, 7)));
         set_idling(phase < PHASES - 1 && $urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) begin
            // result side holds off while short strings keep coming
            set_idling(1'b0);
            @(posedge clock);
            hold_token++;
            repeat (HOLD_STRINGS) begin
               put_token();
               send_draft();
            end
            set_idling(1'b1);
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            repeat ($urandom_range(1, 6)) put_token();
            send_draft();
         end
      end

      wait_results();
      $display("Checked %0d strings from %0d bytes across all eight class masks,",
               strings_checked, bytes_sent);
      $display("with broken, truncated and overlong sequences, a long hold-off and stalls.");
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
